### rtl/mrmxy_pkg.sv
// Shared types and constants for the multichannel running median block.
// No dependencies; every other file in the block imports this package.
package mrmxy_pkg;

   // Fixed field widths of the request and response transactions.
   localparam int CH_W     = 3;
   localparam int COORD_W  = 16;
   // Width to which the channel number is widened before it is range checked.
   localparam int CH_EXT_W = 7;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // request transaction accepted: latch fields, read state
      logic update;    // write sample and channel state, clear the sorters
      logic issue;     // read one window sample into the sorters
      logic finish;    // load the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic ch_ok;       // incoming channel number is in range
      logic last_issue;  // the read being issued is the last of the window
      logic out_free;    // the response register can take a new result
   } sts_type;

endpackage

### rtl/mrmxy_req_if.sv
// Request channel interface: valid/ready handshake with one X,Y sample.
// Depends on mrmxy_pkg for the field widths.
interface mrmxy_req_if;
   import mrmxy_pkg::*;

   logic               valid;
   logic               ready;
   logic [CH_W-1:0]    channel;
   logic               restart;
   logic [COORD_W-1:0] x_coord;
   logic [COORD_W-1:0] y_coord;

   modport source (output valid, output channel, output restart, output x_coord,
                   output y_coord, input ready);
   modport sink   (input valid, input channel, input restart, input x_coord,
                   input y_coord, output ready);
endinterface

### rtl/mrmxy_rsp_if.sv
// Response channel interface: valid/ready handshake with the X and Y medians.
// Depends on mrmxy_pkg for the field widths.
interface mrmxy_rsp_if;
   import mrmxy_pkg::*;

   logic               valid;
   logic               ready;
   logic [CH_W-1:0]    out_channel;
   logic [COORD_W-1:0] median_x;
   logic [COORD_W-1:0] median_y;

   modport source (output valid, output out_channel, output median_x,
                   output median_y, input ready);
   modport sink   (input valid, input out_channel, input median_x,
                   input median_y, output ready);
endinterface

### rtl/mrmxy_ctrl.sv
// Controller state machine of the running median block.
// Depends on mrmxy_pkg for the command and status structs.
module mrmxy_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  mrmxy_pkg::sts_type sts,
   output mrmxy_pkg::cmd_type cmd
);
   import mrmxy_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UPDATE,
      S_READ,
      S_DRAIN,
      S_FINISH
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && sts.ch_ok) state_in = S_UPDATE;
         end
         S_UPDATE: begin
            state_in = S_READ;
         end
         S_READ: begin
            if (sts.last_issue) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (sts.out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready   = (state_ff == S_IDLE);
   assign cmd.capture = req_ready && req_valid;
   assign cmd.update  = (state_ff == S_UPDATE);
   assign cmd.issue   = (state_ff == S_READ);
   assign cmd.finish  = (state_ff == S_FINISH) && sts.out_free;

endmodule

### rtl/mrmxy_dpath.sv
// Datapath of the running median block: sample and channel state memories,
// insertion sorters for X and Y, and the response register. Depends on mrmxy_pkg.
module mrmxy_dpath #(
   parameter int WINDOW   = 8,
   parameter int CHANNELS = 8
) (
   input  logic                          clock,
   input  logic                          reset,
   input  mrmxy_pkg::cmd_type            cmd,
   output mrmxy_pkg::sts_type            sts,
   input  logic [mrmxy_pkg::CH_W-1:0]    req_channel,
   input  logic                          req_restart,
   input  logic [mrmxy_pkg::COORD_W-1:0] req_x,
   input  logic [mrmxy_pkg::COORD_W-1:0] req_y,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [mrmxy_pkg::CH_W-1:0]    rsp_channel,
   output logic [mrmxy_pkg::COORD_W-1:0] rsp_median_x,
   output logic [mrmxy_pkg::COORD_W-1:0] rsp_median_y
);
   import mrmxy_pkg::*;

   localparam int CHW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DEPTH = CHANNELS * WINDOW;
   localparam int AW    = $clog2(DEPTH);
   localparam int PW    = $clog2(WINDOW);
   localparam int NW    = $clog2(WINDOW + 1);
   localparam int SW    = 2 * COORD_W;
   localparam int STW   = NW + PW;

   // Captured request fields.
   logic [CH_W-1:0]    ch_ff;
   logic               restart_ff;
   logic [COORD_W-1:0] x_ff;
   logic [COORD_W-1:0] y_ff;

   // Channel state: fill count and write position, with a valid bit per channel.
   logic [STW-1:0]      state_mem [CHANNELS];
   logic [CHANNELS-1:0] vld_ff;
   logic [STW-1:0]      state_rd_ff;
   logic                vld_rd_ff;

   // Window samples, X in the upper half and Y in the lower half of an entry.
   logic [SW-1:0] sample_mem [DEPTH];
   logic [SW-1:0] rd_data_ff;
   logic          rd_vld_ff;

   logic [AW-1:0] base_ff;
   logic [NW-1:0] n_ff;
   logic [PW-1:0] rd_idx_ff;

   // Sorted lists, ascending, with occupancy shared by X and Y.
   logic [COORD_W-1:0] xs_ff [WINDOW];
   logic [COORD_W-1:0] ys_ff [WINDOW];
   logic [COORD_W-1:0] xs_in [WINDOW];
   logic [COORD_W-1:0] ys_in [WINDOW];
   logic [WINDOW-1:0]  occ_ff;
   logic [WINDOW-1:0]  gt_x;
   logic [WINDOW-1:0]  gt_y;

   logic               rsp_valid_ff;
   logic [CH_W-1:0]    rsp_ch_ff;
   logic [COORD_W-1:0] rsp_x_ff;
   logic [COORD_W-1:0] rsp_y_ff;

   logic [CH_EXT_W-1:0] req_ch_ext;
   logic [CH_EXT_W-1:0] ch_ext;
   logic [CHW-1:0]      req_idx;
   logic [CHW-1:0]      ch_idx;
   logic [NW-1:0]       n_old;
   logic [PW-1:0]       pos_old;
   logic [NW-1:0]       n_new;
   logic [PW-1:0]       pos_new;
   logic [AW-1:0]       base;
   logic [COORD_W-1:0]  vx;
   logic [COORD_W-1:0]  vy;
   logic [PW-1:0]       mid;

   assign req_ch_ext = {{(CH_EXT_W - CH_W){1'b0}}, req_channel};
   assign ch_ext     = {{(CH_EXT_W - CH_W){1'b0}}, ch_ff};
   assign req_idx    = req_ch_ext[CHW-1:0];
   assign ch_idx     = ch_ext[CHW-1:0];

   // A restart or a channel never written since reset starts from an empty window.
   always_comb begin
      if (vld_rd_ff && !restart_ff) begin
         n_old   = state_rd_ff[STW-1:PW];
         pos_old = state_rd_ff[PW-1:0];
      end else begin
         n_old   = '0;
         pos_old = '0;
      end
      n_new   = (n_old < NW'(WINDOW)) ? n_old + NW'(1) : NW'(WINDOW);
      pos_new = (pos_old == PW'(WINDOW - 1)) ? '0 : pos_old + PW'(1);
      base    = AW'(ch_idx * WINDOW);
   end

   assign sts.ch_ok      = (req_ch_ext < CH_EXT_W'(CHANNELS));
   assign sts.last_issue = (NW'(rd_idx_ff) + NW'(1) == n_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         ch_ff       <= req_channel;
         restart_ff  <= req_restart;
         x_ff        <= req_x;
         y_ff        <= req_y;
         state_rd_ff <= state_mem[req_idx];
         vld_rd_ff   <= vld_ff[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         state_mem[ch_idx]                  <= {n_new, pos_new};
         sample_mem[base + AW'(pos_old)]    <= {x_ff, y_ff};
         base_ff                            <= base;
         n_ff                               <= n_new;
      end
      if (cmd.issue) begin
         rd_data_ff <= sample_mem[base_ff + AW'(rd_idx_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         rd_vld_ff <= 1'b0;
         rd_idx_ff <= '0;
         occ_ff    <= '0;
      end else begin
         rd_vld_ff <= cmd.issue;
         if (cmd.update) begin
            vld_ff[ch_idx] <= 1'b1;
            rd_idx_ff      <= '0;
            occ_ff         <= '0;
         end else begin
            if (cmd.issue) rd_idx_ff <= rd_idx_ff + PW'(1);
            if (rd_vld_ff) occ_ff <= {occ_ff[WINDOW-2:0], 1'b1};
         end
      end
   end

   // Insertion step: every cell above the new value shifts up by one place.
   assign vx = rd_data_ff[SW-1:COORD_W];
   assign vy = rd_data_ff[COORD_W-1:0];

   for (genvar i = 0; i < WINDOW; i++) begin : g_cell
      assign gt_x[i] = !occ_ff[i] || (xs_ff[i] > vx);
      assign gt_y[i] = !occ_ff[i] || (ys_ff[i] > vy);
      if (i == 0) begin : g_first
         assign xs_in[i] = gt_x[i] ? vx : xs_ff[i];
         assign ys_in[i] = gt_y[i] ? vy : ys_ff[i];
      end else begin : g_rest
         assign xs_in[i] = gt_x[i] ? (gt_x[i-1] ? xs_ff[i-1] : vx) : xs_ff[i];
         assign ys_in[i] = gt_y[i] ? (gt_y[i-1] ? ys_ff[i-1] : vy) : ys_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_vld_ff) begin
         xs_ff <= xs_in;
         ys_ff <= ys_in;
      end
   end

   // The median is sorted element floor(n/2).
   assign mid = PW'(n_ff >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_ch_ff <= ch_ff;
         rsp_x_ff  <= xs_ff[mid];
         rsp_y_ff  <= ys_ff[mid];
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_channel  = rsp_ch_ff;
   assign rsp_median_x = rsp_x_ff;
   assign rsp_median_y = rsp_y_ff;

endmodule

### rtl/multichannel_running_median_xy.sv
// An accepted request passes the update, read, drain and finish states; the read
// state fetches the n window samples, n being the channel's sample count after
// the update (1..WINDOW), one sample a cycle through the single read port of the
// sample memory. A new request waits for finish, which stalls while a result waits.
// Reset is synchronous and active high; it empties every channel at once and
// clears the response valid. Sample storage is not cleared and needs no pass.
module multichannel_running_median_xy #(
   parameter int WINDOW   = 8,
   parameter int CHANNELS = 8
) (
   input logic         clock,
   input logic         reset,
   mrmxy_req_if.sink   req_chan,
   mrmxy_rsp_if.source rsp_chan
);
   import mrmxy_pkg::*;

   // Commands and status between the controller and the datapath.
   cmd_type cmd;
   sts_type sts;

   // The controller walks each transaction through its steps: capture the
   // fields and read the channel state, update the window, stream the valid
   // samples through the sorters, then hand the median to the response register.
   // A transaction with a channel at or above CHANNELS is accepted and dropped.
   mrmxy_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds all storage. The response register is separate from the
   // working state, so a new request is taken while a result still waits.
   mrmxy_dpath #(
      .WINDOW   (WINDOW),
      .CHANNELS (CHANNELS)
   ) u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .sts          (sts),
      .req_channel  (req_chan.channel),
      .req_restart  (req_chan.restart),
      .req_x        (req_chan.x_coord),
      .req_y        (req_chan.y_coord),
      .rsp_ready    (rsp_chan.ready),
      .rsp_valid    (rsp_chan.valid),
      .rsp_channel  (rsp_chan.out_channel),
      .rsp_median_x (rsp_chan.median_x),
      .rsp_median_y (rsp_chan.median_y)
   );

endmodule

### rtl/mrmxy_checker.sv
// Port-level checks of the running median block, attached by a bind statement.
// Depends on mrmxy_pkg and the request and response interfaces.
module mrmxy_checker #(
   parameter int CHANNELS = 8
) (
   input logic         clock,
   input logic         reset,
   mrmxy_req_if.sink   req_chan,
   mrmxy_rsp_if.source rsp_chan
);
   import mrmxy_pkg::*;

   // A waiting response stays valid.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=> rsp_chan.valid)
      else $error("response valid dropped while stalled");

   // A waiting response keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         $stable(rsp_chan.out_channel) && $stable(rsp_chan.median_x)
         && $stable(rsp_chan.median_y))
      else $error("response payload changed while stalled");

   // An in-range request occupies the block, so ready drops the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready && (req_chan.channel < CHANNELS)
         |=> !req_chan.ready)
      else $error("request taken while a transaction is in progress");

   // A new result is loaded only at the end of a transaction's work.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_chan.valid) |-> $past(!req_chan.ready))
      else $error("response appeared while the block was idle");

   // Results belong to channels that exist.
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.out_channel < CHANNELS))
      else $error("response for a channel out of range");

endmodule

bind multichannel_running_median_xy mrmxy_checker #(
   .CHANNELS (CHANNELS)
) u_mrmxy_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);
